// ----- rtl/dtsv_pkg.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator package
// Shared item type, slot codes and calendar helpers.
// ----------------------------------------------------------------------------
package dtsv_pkg;

    // layouts
    localparam logic [2:0] FMT_DATE     = 3'd0;
    localparam logic [2:0] FMT_TIME     = 3'd1;
    localparam logic [2:0] FMT_DATETIME = 3'd2;
    localparam logic [2:0] FMT_SEP_DATE = 3'd3;
    localparam logic [2:0] FMT_SEP_TIME = 3'd4;

    // per-position slot codes
    localparam logic [3:0] SLOT_YEAR   = 4'd0;
    localparam logic [3:0] SLOT_SECOND = 4'd5;
    localparam logic [3:0] SLOT_SEP    = 4'd6;
    localparam logic [3:0] SLOT_OVER   = 4'd7;
    localparam logic [3:0] SLOT_SKIP   = 4'd8;

    // back-end operations
    localparam logic [2:0] OP_YEAR   = 3'd0;
    localparam logic [2:0] OP_MONTH  = 3'd1;
    localparam logic [2:0] OP_DAY    = 3'd2;
    localparam logic [2:0] OP_HOUR   = 3'd3;
    localparam logic [2:0] OP_MINUTE = 3'd4;
    localparam logic [2:0] OP_SECOND = 3'd5;
    localparam logic [2:0] OP_NONE   = 3'd6;
    localparam logic [2:0] OP_BAD    = 3'd7;

    localparam logic [3:0] POS_MAX = 4'd15;

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    // slot rows, position 0 in the lowest nibble
    localparam logic [63:0] ROW_DATE     = 64'h7777_7777_2211_0000;
    localparam logic [63:0] ROW_TIME     = 64'h7777_7777_7755_4433;
    localparam logic [63:0] ROW_DATETIME = 64'h8855_4433_2211_0000;
    localparam logic [63:0] ROW_SEP_DATE = 64'h7777_7722_6116_0000;
    localparam logic [63:0] ROW_SEP_TIME = 64'h7777_7777_5564_4633;

    typedef struct packed {
        logic [2:0] op;
        logic [3:0] digit;
        logic       last;
        logic       need_date;
        logic       need_time;
        logic       form_ok;
    } dtsv_item_t;

    function automatic logic [3:0] slot_lookup(input logic [2:0] fmt, input logic [3:0] pos);
        logic [63:0] row;
        begin
            unique case (fmt)
                FMT_DATE:     row = ROW_DATE;
                FMT_TIME:     row = ROW_TIME;
                FMT_DATETIME: row = ROW_DATETIME;
                FMT_SEP_DATE: row = ROW_SEP_DATE;
                FMT_SEP_TIME: row = ROW_SEP_TIME;
                default:      row = '1;
            endcase
            slot_lookup = row[{pos, 2'b00} +: 4];
        end
    endfunction

    // valid only for years inside 1700..3000
    function automatic logic is_leap(input logic [13:0] y);
        logic century;
        begin
            century = 1'b0;
            for (int c = 17; c <= 30; c++)
            begin
                if (y == 14'(c * 100))
                    century = 1'b1;
            end
            is_leap = (y[1:0] == 2'b00 && !century) || y == 14'd2000 || y == 14'd2400
                   || y == 14'd2800 || y == 14'd3000;
        end
    endfunction

    function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
        begin
            unique case (m)
                7'd2:                          month_len = leap ? 5'd29 : 5'd28;
                7'd4, 7'd6, 7'd9, 7'd11:       month_len = 5'd30;
                default:                       month_len = 5'd31;
            endcase
        end
    endfunction

endpackage

// ----- rtl/dtsv_front.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator front end
// Tracks position, layout and end of string; classifies each byte.
// ----------------------------------------------------------------------------
module dtsv_front
    import dtsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  logic [2:0] mode,
    input  logic [7:0] char_byte,
    input  logic       last,
    output dtsv_item_t item
);

    logic [3:0] pos_reg, pos_next, pos_adv;
    logic       ended_reg, ended_next;
    logic [2:0] fmt_reg, fmt_next, fmt_eff;
    logic       live, is_digit;
    logic [3:0] slot;

    always_comb
    begin
        fmt_eff  = (pos_reg == 4'd0 && !ended_reg) ? mode : fmt_reg;
        live     = !ended_reg && char_byte != 8'd0;
        is_digit = char_byte >= 8'h30 && char_byte <= 8'h39;
        slot     = slot_lookup(fmt_eff, pos_reg);
        pos_adv  = (live && pos_reg != POS_MAX) ? pos_reg + 4'd1 : pos_reg;

        item.digit = char_byte[3:0];
        item.last  = last;
        if (!live)
            item.op = OP_NONE;
        else if (fmt_eff > FMT_SEP_TIME)
            item.op = OP_BAD;
        else if (slot <= SLOT_SECOND)
            item.op = is_digit ? slot[2:0] : OP_BAD;
        else if (slot == SLOT_OVER)
            item.op = OP_BAD;
        else
            item.op = OP_NONE;

        unique case (fmt_eff)
            FMT_DATE:     item.form_ok = pos_adv == 4'd8;
            FMT_TIME:     item.form_ok = pos_adv == 4'd6;
            FMT_DATETIME: item.form_ok = pos_adv >= 4'd14;
            FMT_SEP_DATE: item.form_ok = pos_adv == 4'd10;
            FMT_SEP_TIME: item.form_ok = pos_adv == 4'd8;
            default:      item.form_ok = 1'b0;
        endcase
        item.need_date = fmt_eff == FMT_DATE || fmt_eff == FMT_DATETIME
                      || fmt_eff == FMT_SEP_DATE;
        item.need_time = fmt_eff == FMT_TIME || fmt_eff == FMT_DATETIME
                      || fmt_eff == FMT_SEP_TIME;

        // start over after the last byte of a string
        if (last)
        begin
            pos_next   = 4'd0;
            ended_next = 1'b0;
            fmt_next   = FMT_DATE;
        end
        else
        begin
            pos_next   = pos_adv;
            ended_next = ended_reg || char_byte == 8'd0;
            fmt_next   = fmt_eff;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 4'd0;
            ended_reg <= 1'b0;
            fmt_reg   <= FMT_DATE;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            ended_reg <= ended_next;
            fmt_reg   <= fmt_next;
        end
    end

endmodule

// ----- rtl/dtsv_queue.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator queue
// Small register queue between the front and back ends.
// ----------------------------------------------------------------------------
module dtsv_queue
    import dtsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  dtsv_item_t push_item,
    output logic       full,
    input  logic       pop,
    output logic       nonempty,
    output dtsv_item_t head
);

    dtsv_item_t            slots_reg [QDEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCOUNT_W-1:0]   count_reg, count_next;

    assign full     = count_reg == QCOUNT_W'(QDEPTH);
    assign nonempty = count_reg != '0;
    assign head     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/dtsv_back.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator back end
// Accumulates decimal fields and judges the string on its last item.
// ----------------------------------------------------------------------------
module dtsv_back
    import dtsv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       nonempty,
    input  dtsv_item_t head,
    output logic       pop,
    output logic       res_valid,
    input  logic       res_ready,
    output logic       valid_res
);

    logic [13:0] year_reg, year_next;
    logic [6:0]  month_reg, month_next, day_reg, day_next;
    logic [6:0]  hour_reg, hour_next, minute_reg, minute_next, second_reg, second_next;
    logic        ok_reg, ok_next;
    logic        out_valid_reg, out_res_reg;
    logic        load, date_ok, time_ok, verdict;
    logic [4:0]  lim;

    function automatic logic [6:0] push7(input logic [6:0] acc, input logic [3:0] d);
        logic [10:0] s;
        begin
            s = {acc, 3'b000} + {3'b000, acc, 1'b0} + {7'd0, d};
            push7 = s[6:0];
        end
    endfunction

    assign pop       = nonempty && (!head.last || !out_valid_reg || res_ready);
    assign load      = pop && head.last;
    assign res_valid = out_valid_reg;
    assign valid_res = out_res_reg;

    always_comb
    begin
        year_next   = year_reg;
        month_next  = month_reg;
        day_next    = day_reg;
        hour_next   = hour_reg;
        minute_next = minute_reg;
        second_next = second_reg;
        ok_next     = ok_reg;
        unique case (head.op)
            OP_YEAR:   year_next   = 14'({year_reg, 3'b000} + {year_reg, 1'b0}
                                        + 17'(head.digit));
            OP_MONTH:  month_next  = push7(month_reg, head.digit);
            OP_DAY:    day_next    = push7(day_reg, head.digit);
            OP_HOUR:   hour_next   = push7(hour_reg, head.digit);
            OP_MINUTE: minute_next = push7(minute_reg, head.digit);
            OP_SECOND: second_next = push7(second_reg, head.digit);
            OP_BAD:    ok_next     = 1'b0;
            OP_NONE:   ok_next     = ok_reg;
            default:   ok_next     = ok_reg;
        endcase

        lim     = month_len(month_next, is_leap(year_next));
        date_ok = year_next >= 14'd1700 && year_next <= 14'd3000
               && month_next >= 7'd1 && month_next <= 7'd12
               && day_next >= 7'd1 && day_next <= {2'b00, lim};
        time_ok = hour_next <= 7'd23 && minute_next <= 7'd59 && second_next <= 7'd59;
        verdict = ok_next && head.form_ok && (!head.need_date || date_ok)
               && (!head.need_time || time_ok);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            year_reg      <= '0;
            month_reg     <= '0;
            day_reg       <= '0;
            hour_reg      <= '0;
            minute_reg    <= '0;
            second_reg    <= '0;
            ok_reg        <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                // clear the fields once a string is judged
                if (head.last)
                begin
                    year_reg   <= '0;
                    month_reg  <= '0;
                    day_reg    <= '0;
                    hour_reg   <= '0;
                    minute_reg <= '0;
                    second_reg <= '0;
                    ok_reg     <= 1'b1;
                end
                else
                begin
                    year_reg   <= year_next;
                    month_reg  <= month_next;
                    day_reg    <= day_next;
                    hour_reg   <= hour_next;
                    minute_reg <= minute_next;
                    second_reg <= second_next;
                    ok_reg     <= ok_next;
                end
            end
            if (load)
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_res_reg <= verdict;
    end

endmodule

// ----- rtl/date_time_string_validator.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator
// Checks ASCII date/time strings, one byte per item, one result per string.
// ----------------------------------------------------------------------------
// Result path: the item marked last is registered in the queue, then popped
// into the output register if nothing is ahead of it and the register is free.
// Throughput: one byte per cycle while the queue is not full; the 4-entry
// queue between the classifier and the accumulators absorbs output stalls.
// Reset: rst_n clears position, layout, accumulators and queue at once;
// the block is ready to take items as soon as reset is released.
module date_time_string_validator
    import dtsv_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [2:0] mode, [10:3] char_byte, [15:11] zero
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] valid_res, [7:1] zero
);

    dtsv_item_t front_item, head;
    logic       take, full, nonempty, pop, valid_res;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;
    assign m_tdata  = {7'd0, valid_res};

    dtsv_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .mode      (s_tdata[2:0]),
        .char_byte (s_tdata[10:3]),
        .last      (s_tlast),
        .item      (front_item)
    );

    dtsv_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (take),
        .push_item (front_item),
        .full      (full),
        .pop       (pop),
        .nonempty  (nonempty),
        .head      (head)
    );

    dtsv_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .nonempty  (nonempty),
        .head      (head),
        .pop       (pop),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .valid_res (valid_res)
    );

endmodule

// ----- tb/sv/date_time_string_validator_tb.sv -----
// ----------------------------------------------------------------------------
// Date/time string validator testbench
// Streams ASCII strings in all five layouts into the validator and scores
// each one-bit verdict against a cycle-free model of the calendar and clock
// checks. Directed strings cover the boundaries. Random strings are mostly
// well formed, with bad fields, bad lengths and noise mixed in. Both stream
// sides idle at random.
// ----------------------------------------------------------------------------
module date_time_string_validator_tb;
    import dtsv_pkg::*;

    typedef enum logic [3:0] {
        K_YEAR, K_MONTH, K_DAY, K_HOUR, K_MINUTE, K_SECOND, K_SEP, K_OVER, K_SKIP
    } slot_kind_t;

    typedef struct {
        logic [2:0] mode;
        logic [7:0] ch;
        logic       last;
        bit         drain_first;
    } in_item_t;

    localparam int RANDOM_ITEMS = 1200;
    localparam int HOLD_AFTER   = 30;
    localparam int HOLD_CYCLES  = 150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;     // [2:0] mode, [10:3] char_byte, [15:11] zero
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [0] valid_res, [7:1] zero

    in_item_t    pending[$];
    logic [7:0]  str_buf[$];
    logic        verdicts_due[$];
    logic        none_due = 1'b1;
    int          items_made = 0;
    int          err_count = 0;
    int          results_seen = 0;
    int          send_gap = 0;
    int          send_calm = 0;
    int          take_wait = 0;
    int          take_calm = 0;
    int          long_hold = 0;
    bit          long_hold_done = 1'b0;

    // model state
    logic [3:0]  ts_pos = '0;
    logic [2:0]  ts_fmt = '0;
    logic [13:0] ts_year = '0;
    logic [6:0]  ts_month = '0;
    logic [6:0]  ts_day = '0;
    logic [6:0]  ts_hour = '0;
    logic [6:0]  ts_minute = '0;
    logic [6:0]  ts_second = '0;
    logic        ts_ok = 1'b1;
    logic        ts_ended = 1'b0;

    date_time_string_validator u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #(12 * 200000);
        $display("FAILURE");
        $finish;
    end

    task automatic flag_error(input string what);
        err_count++;
        if (err_count <= 40)
            $display("mismatch at %0t: %s", $time, what);
    endtask

    function automatic slot_kind_t slot_at(input logic [2:0] fmt, input logic [3:0] pos);
        slot_kind_t k;
        k = K_OVER;
        case (fmt)
            FMT_DATE:
                k = (pos < 4) ? K_YEAR : (pos < 6) ? K_MONTH : (pos < 8) ? K_DAY : K_OVER;
            FMT_TIME:
                k = (pos < 2) ? K_HOUR : (pos < 4) ? K_MINUTE : (pos < 6) ? K_SECOND : K_OVER;
            FMT_DATETIME:
                k = (pos < 4) ? K_YEAR : (pos < 6) ? K_MONTH : (pos < 8) ? K_DAY :
                    (pos < 10) ? K_HOUR : (pos < 12) ? K_MINUTE : (pos < 14) ? K_SECOND :
                    K_SKIP;
            FMT_SEP_DATE:
                k = (pos < 4) ? K_YEAR : (pos == 4 || pos == 7) ? K_SEP :
                    (pos < 7) ? K_MONTH : (pos < 10) ? K_DAY : K_OVER;
            FMT_SEP_TIME:
                k = (pos < 2) ? K_HOUR : (pos == 2 || pos == 5) ? K_SEP :
                    (pos < 5) ? K_MINUTE : (pos < 8) ? K_SECOND : K_OVER;
            default:
                k = K_OVER;
        endcase
        return k;
    endfunction

    function automatic bit leap_year(input int y);
        return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0 || y % 1000 == 0;
    endfunction

    function automatic bit calendar_ok();
        int lim;
        if (ts_year < 1700 || ts_year > 3000)
            return 1'b0;
        if (ts_month < 1 || ts_month > 12)
            return 1'b0;
        case (ts_month)
            7'd2:                    lim = leap_year(ts_year) ? 29 : 28;
            7'd4, 7'd6, 7'd9, 7'd11: lim = 30;
            default:                 lim = 31;
        endcase
        return ts_day >= 1 && ts_day <= lim;
    endfunction

    function automatic bit clock_ok();
        return ts_hour <= 23 && ts_minute <= 59 && ts_second <= 59;
    endfunction

    function automatic bit string_passes();
        if (!ts_ok || ts_fmt > FMT_SEP_TIME)
            return 1'b0;
        case (ts_fmt)
            FMT_DATETIME: return ts_pos >= 14 && calendar_ok() && clock_ok();
            FMT_DATE:     return ts_pos == 8 && calendar_ok();
            FMT_SEP_DATE: return ts_pos == 10 && calendar_ok();
            FMT_TIME:     return ts_pos == 6 && clock_ok();
            default:      return ts_pos == 8 && clock_ok();
        endcase
    endfunction

    // Fold one accepted byte into the model; queue the verdict on the last byte.
    task automatic predict_timestamp_byte(input logic [2:0] md, input logic [7:0] c,
                                          input logic fin);
        slot_kind_t k;
        int d;
        if (ts_pos == 0 && !ts_ended)
            ts_fmt = md;
        if (!ts_ended)
        begin
            if (c == 8'd0)
                ts_ended = 1'b1;
            else
            begin
                if (ts_fmt > FMT_SEP_TIME)
                    ts_ok = 1'b0;
                else
                begin
                    k = slot_at(ts_fmt, ts_pos);
                    d = int'(c) - int'("0");
                    if (k <= K_SECOND && (c < "0" || c > "9"))
                        ts_ok = 1'b0;
                    else
                    begin
                        case (k)
                            K_YEAR:   ts_year = 14'(int'(ts_year) * 10 + d);
                            K_MONTH:  ts_month = 7'(int'(ts_month) * 10 + d);
                            K_DAY:    ts_day = 7'(int'(ts_day) * 10 + d);
                            K_HOUR:   ts_hour = 7'(int'(ts_hour) * 10 + d);
                            K_MINUTE: ts_minute = 7'(int'(ts_minute) * 10 + d);
                            K_SECOND: ts_second = 7'(int'(ts_second) * 10 + d);
                            K_OVER:   ts_ok = 1'b0;
                            default:  ;
                        endcase
                    end
                end
                if (ts_pos != POS_MAX)
                    ts_pos = ts_pos + 4'd1;
            end
        end
        if (fin)
        begin
            verdicts_due.push_back(string_passes());
            ts_pos = '0;
            ts_fmt = '0;
            ts_year = '0;
            ts_month = '0;
            ts_day = '0;
            ts_hour = '0;
            ts_minute = '0;
            ts_second = '0;
            ts_ok = 1'b1;
            ts_ended = 1'b0;
        end
    endtask

    function automatic int idle_draw(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0)
        begin
            calm = $urandom_range(20, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    task automatic put_char(input logic [7:0] c);
        str_buf.push_back(c);
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    task automatic put_num(input int v, input int ndig);
        int p;
        p = 1;
        for (int i = 1; i < ndig; i++)
            p = p * 10;
        for (int i = 0; i < ndig; i++)
        begin
            put_char(8'(int'("0") + (v / p) % 10));
            p = p / 10;
        end
    endtask

    // Move the built string into the send queue; later bytes carry junk modes.
    task automatic flush_string(input logic [2:0] layout);
        in_item_t it;
        for (int i = 0; i < str_buf.size(); i++)
        begin
            it.mode = (i == 0) ? layout : 3'($urandom_range(0, 7));
            it.ch = str_buf[i];
            it.last = (i == str_buf.size() - 1);
            it.drain_first = 1'b0;
            pending.push_back(it);
        end
        items_made += str_buf.size();
        str_buf.delete();
    endtask

    task automatic queue_drain_pause();
        in_item_t it;
        it.mode = '0;
        it.ch = '0;
        it.last = 1'b0;
        it.drain_first = 1'b1;
        pending.push_back(it);
    endtask

    task automatic make_random_string();
        int layout, shape, yr, mo, dy, hr, mi, se, idx;
        logic [7:0] sep1, sep2;
        layout = $urandom_range(0, 4);
        if ($urandom_range(0, 19) == 0)
            layout = $urandom_range(5, 7);
        shape = (layout > 4) ? $urandom_range(0, 4) : layout;
        case ($urandom_range(0, 7))
            0:
            begin
                case ($urandom_range(0, 7))
                    0: yr = 1699;
                    1: yr = 1700;
                    2: yr = 3000;
                    3: yr = 3001;
                    4: yr = 2000;
                    5: yr = 1900;
                    6: yr = 2100;
                    default: yr = 2400;
                endcase
            end
            1: yr = $urandom_range(0, 9999);
            default: yr = $urandom_range(1690, 3010);
        endcase
        mo = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
        if ($urandom_range(0, 3) == 0)
            mo = 2;
        case ($urandom_range(0, 5))
            0: dy = $urandom_range(0, 99);
            1, 2: dy = $urandom_range(28, 31);
            default: dy = $urandom_range(1, 28);
        endcase
        hr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
        mi = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        se = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
        if ($urandom_range(0, 5) == 0)
        begin
            hr = 23;
            mi = 59;
            se = 59;
        end
        sep1 = 8'($urandom_range(1, 255));
        sep2 = 8'($urandom_range(1, 255));
        case (shape)
            0:
            begin
                put_num(yr, 4);
                put_num(mo, 2);
                put_num(dy, 2);
            end
            1:
            begin
                put_num(hr, 2);
                put_num(mi, 2);
                put_num(se, 2);
            end
            2:
            begin
                put_num(yr, 4);
                put_num(mo, 2);
                put_num(dy, 2);
                put_num(hr, 2);
                put_num(mi, 2);
                put_num(se, 2);
                if ($urandom_range(0, 2) == 0)
                begin
                    repeat ($urandom_range(1, 6))
                        put_char(8'($urandom_range(0, 255)));
                end
            end
            3:
            begin
                put_num(yr, 4);
                put_char(sep1);
                put_num(mo, 2);
                put_char(sep2);
                put_num(dy, 2);
            end
            default:
            begin
                put_num(hr, 2);
                put_char(sep1);
                put_num(mi, 2);
                put_char(sep2);
                put_num(se, 2);
            end
        endcase
        idx = $urandom_range(0, str_buf.size() - 1);
        case ($urandom_range(0, 11))
            0: str_buf[idx] = 8'($urandom_range(0, 255));
            1: str_buf[idx] = 8'd0;
            2: if (str_buf.size() > 1) void'(str_buf.pop_back());
            3: put_char(8'($urandom_range(int'("0"), int'("9"))));
            default: ;
        endcase
        flush_string(3'(layout));
    endtask

    task automatic make_noise_string();
        repeat ($urandom_range(1, 18))
            put_char(($urandom_range(0, 7) == 0) ? 8'd0 : 8'($urandom_range(0, 255)));
        flush_string(3'($urandom_range(0, 7)));
    endtask

    // Driver: present queued items, honor per-item gaps and drain pauses.
    always @(posedge clk or negedge rst_n)
    begin : feeder
        in_item_t it;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            send_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (send_gap != 0)
            begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending.size() == 0)
                s_tvalid <= 1'b0;
            else if (pending[0].drain_first)
            begin
                // hold until every verdict already sent has been read out
                s_tvalid <= 1'b0;
                if (!s_tvalid && none_due)
                    pending.delete(0);
            end
            else
            begin
                it = pending.pop_front();
                s_tdata <= {5'd0, it.ch, it.mode};
                s_tlast <= it.last;
                s_tvalid <= 1'b1;
                send_gap <= idle_draw(send_calm);
            end
        end
    end

    // Receiver: random wait per result, plus one long hold to back up the input.
    always @(posedge clk or negedge rst_n)
    begin : reader
        int w;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            take_wait <= 0;
            long_hold <= 0;
            long_hold_done <= 1'b0;
        end
        else if (long_hold != 0)
        begin
            m_tready <= 1'b0;
            long_hold <= long_hold - 1;
        end
        else if (!long_hold_done && results_seen >= HOLD_AFTER)
        begin
            m_tready <= 1'b0;
            long_hold <= HOLD_CYCLES;
            long_hold_done <= 1'b1;
        end
        else if (m_tvalid && m_tready)
        begin
            w = idle_draw(take_calm);
            take_wait <= w;
            m_tready <= (w == 0);
        end
        else if (take_wait != 0)
        begin
            take_wait <= take_wait - 1;
            m_tready <= (take_wait == 1);
        end
        else
            m_tready <= 1'b1;
    end

    // Monitor: predict on input handshakes, score on output handshakes.
    always @(posedge clk)
    begin : scorer
        logic want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_timestamp_byte(s_tdata[2:0], s_tdata[10:3], s_tlast);
            if (m_tvalid && m_tready)
            begin
                results_seen <= results_seen + 1;
                if (verdicts_due.size() == 0)
                    flag_error($sformatf("verdict %0b with none due", m_tdata[0]));
                else
                begin
                    want = verdicts_due.pop_front();
                    if (m_tdata[0] !== want)
                        flag_error($sformatf("valid_res %0b, expected %0b", m_tdata[0], want));
                end
                if (m_tdata[7:1] !== 7'd0)
                    flag_error($sformatf("padding bits %b not zero", m_tdata[7:1]));
            end
            none_due <= (verdicts_due.size() == 0);
        end
    end

    initial
    begin
        // boundaries of each layout
        put_text("17000101");
        flush_string(FMT_DATE);
        put_text("235959");
        flush_string(FMT_TIME);
        put_text("30000229235959");
        flush_string(FMT_DATETIME);
        put_text("2024-02-29");
        flush_string(FMT_SEP_DATE);
        put_text("00");
        put_char(8'hFF);
        put_text("00");
        put_char(8'h01);
        put_text("00");
        flush_string(FMT_SEP_TIME);
        put_text("16991231");
        flush_string(FMT_DATE);
        put_text("19000229");
        flush_string(FMT_DATE);
        put_text("30011231");
        flush_string(FMT_DATE);
        // long datetime saturates the position count
        put_text("20001231000000XYZWV");
        flush_string(FMT_DATETIME);
        put_text("20001231");
        flush_string(FMT_DATETIME);
        // zero byte ends the string early
        put_text("2000");
        put_char(8'd0);
        put_text("0101");
        flush_string(FMT_DATE);
        put_char(8'd0);
        flush_string(FMT_TIME);
        put_text("2A0000");
        flush_string(FMT_TIME);
        put_text("12345678");
        flush_string(3'd7);
        put_text("300012310");
        flush_string(FMT_DATE);
        put_text("240000");
        flush_string(FMT_TIME);
        put_text("20231131235960");
        flush_string(FMT_DATETIME);
        put_text("21000229");
        flush_string(FMT_DATE);
        put_text("23:60:00");
        flush_string(FMT_SEP_TIME);
        put_text("2000/00/10");
        flush_string(FMT_SEP_DATE);
        queue_drain_pause();

        items_made = 0;
        while (items_made < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 99) < 85)
                make_random_string();
            else
                make_noise_string();
            if (items_made >= RANDOM_ITEMS / 2 && items_made < RANDOM_ITEMS / 2 + 20)
                queue_drain_pause();
        end

        wait (rst_n);
        while (pending.size() != 0 || s_tvalid || !none_due)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- date_time_string_validator.f -----
rtl/dtsv_pkg.sv
rtl/dtsv_front.sv
rtl/dtsv_queue.sv
rtl/dtsv_back.sv
rtl/date_time_string_validator.sv
tb/sv/date_time_string_validator_tb.sv
